FILE: design/dwc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the depthwise convolution block.
// Used by the front end, queue, back end, top level and testbench; depends on nothing.
package dwc_pkg;

    localparam int MaxChannels = 64;
    localparam int MaxMult     = 8;
    localparam int MaxKernel   = 8;
    localparam int MaxWidth    = 256;
    localparam int MaxHeight   = 4096;

    localparam int WeightDepth = MaxKernel * MaxKernel * MaxChannels * MaxMult;
    localparam int LineDepth   = MaxKernel * MaxWidth * MaxChannels;
    localparam int QueueDepth  = 4;

    localparam logic [2:0] REG_HEIGHT   = 3'd0;
    localparam logic [2:0] REG_WIDTH    = 3'd1;
    localparam logic [2:0] REG_CHANNELS = 3'd2;
    localparam logic [2:0] REG_MULT     = 3'd3;
    localparam logic [2:0] REG_KHEIGHT  = 3'd4;
    localparam logic [2:0] REG_KWIDTH   = 3'd5;

    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [14:0]        widx;
        logic signed [15:0] value;
        logic [11:0]        row;
        logic [7:0]         col;
        logic [5:0]         chan;
        logic               win;
    } t_cmd;

    typedef struct packed {
        logic [3:0] mult;
        logic [3:0] kh;
        logic [3:0] kw;
        logic [9:0] cm;
    } t_cfg;

    function automatic logic [12:0] sat13(input logic [12:0] v, input logic [12:0] hi);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: design/dwc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package needed.
module dwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/dwc_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, input acceptance and frame position tracking.
// Depends on dwc_pkg.
module dwc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,
    input  logic                s_axis_tuser,
    input  logic                i_full,
    output logic                o_push,
    output dwc_pkg::t_cmd       o_cmd,
    output dwc_pkg::t_cfg       o_cfg
);
    import dwc_pkg::*;

    logic [12:0] r_h, n_h;
    logic [8:0]  r_w, n_w;
    logic [6:0]  r_c, n_c;
    logic [3:0]  r_m, n_m, r_kh, n_kh, r_kw, n_kw;
    logic [11:0] r_row, n_row;
    logic [7:0]  r_col, n_col;
    logic [5:0]  r_chan, n_chan;
    logic        cfg_we, acc;

    assign o_cfg_ready   = 1'b1;
    assign cfg_we        = i_cfg_valid;
    assign s_axis_tready = !i_full;
    assign acc           = s_axis_tvalid && !i_full;
    assign o_push        = acc;

    always_comb begin
        o_cmd.kind  = s_axis_tuser;
        o_cmd.widx  = s_axis_tdata[14:0];
        o_cmd.value = s_axis_tdata[30:15];
        o_cmd.row   = r_row;
        o_cmd.col   = r_col;
        o_cmd.chan  = r_chan;
        o_cmd.win   = ((13'(r_row) + 13'd1) >= 13'(r_kh)) && ((9'(r_col) + 9'd1) >= 9'(r_kw));
        o_cfg.mult  = r_m;
        o_cfg.kh    = r_kh;
        o_cfg.kw    = r_kw;
        o_cfg.cm    = 10'(10'(r_c) * 10'(r_m));
    end

    always_comb begin
        n_h = r_h; n_w = r_w; n_c = r_c; n_m = r_m; n_kh = r_kh; n_kw = r_kw;
        n_row = r_row; n_col = r_col; n_chan = r_chan;
        if (cfg_we) begin
            n_row = '0; n_col = '0; n_chan = '0;
            unique case (i_cfg_index)
                REG_HEIGHT:   n_h  = sat13(i_cfg_data, 13'(MaxHeight));
                REG_WIDTH:    n_w  = 9'(sat13(13'(i_cfg_data[8:0]), 13'(MaxWidth)));
                REG_CHANNELS: n_c  = 7'(sat13(13'(i_cfg_data[6:0]), 13'(MaxChannels)));
                REG_MULT:     n_m  = 4'(sat13(13'(i_cfg_data[3:0]), 13'(MaxMult)));
                REG_KHEIGHT:  n_kh = 4'(sat13(13'(i_cfg_data[3:0]), 13'(MaxKernel)));
                REG_KWIDTH:   n_kw = 4'(sat13(13'(i_cfg_data[3:0]), 13'(MaxKernel)));
                default: begin
                    n_row = r_row; n_col = r_col; n_chan = r_chan;
                end
            endcase
        end else if (acc && s_axis_tuser == KIND_SAMPLE) begin
            if ((7'(r_chan) + 7'd1) >= r_c) begin
                n_chan = '0;
                if ((9'(r_col) + 9'd1) >= r_w) begin
                    n_col = '0;
                    if ((13'(r_row) + 13'd1) >= r_h) begin
                        n_row = '0;
                    end else begin
                        n_row = r_row + 12'd1;
                    end
                end else begin
                    n_col = r_col + 8'd1;
                end
            end else begin
                n_chan = r_chan + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= 13'd1; r_w <= 9'd1; r_c <= 7'd1; r_m <= 4'd1; r_kh <= 4'd1; r_kw <= 4'd1;
            r_row <= '0; r_col <= '0; r_chan <= '0;
        end else begin
            r_h <= n_h; r_w <= n_w; r_c <= n_c; r_m <= n_m; r_kh <= n_kh; r_kw <= n_kw;
            r_row <= n_row; r_col <= n_col; r_chan <= n_chan;
        end
    end
endmodule

FILE: design/dwc_queue.sv
`timescale 1ns / 1ps
// Small command queue between the front end and the compute back end.
// Depends on dwc_pkg.
module dwc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dwc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output dwc_pkg::t_cmd o_cmd
);
    import dwc_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    t_cmd            r_mem [QueueDepth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [PtrW:0]   r_cnt;

    assign o_full  = (r_cnt == (PtrW+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

FILE: design/dwc_back.sv
`timescale 1ns / 1ps
// Back end: weight and line stores, multiply-accumulate sequencer and output register.
// Depends on dwc_pkg and dwc_ram.
module dwc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  dwc_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  dwc_pkg::t_cfg i_cfg,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [71:0]   m_axis_tdata,
    output logic          m_axis_tlast
);
    import dwc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]         r_st, n_st;
    logic [11:0]        r_r0, n_r0;
    logic [7:0]         r_c0, n_c0;
    logic [5:0]         r_chan, n_chan;
    logic [2:0]         r_q, n_q, r_di, n_di, r_dj, n_dj;
    logic [8:0]         r_wbase, n_wbase;
    logic [14:0]        r_widx, n_widx;
    logic               r_v1, r_v2, issue;
    logic signed [31:0] r_prod;
    logic signed [39:0] r_acc, n_acc;
    logic               r_ov, n_ov, r_olast, n_olast;
    logic [11:0]        r_orow, n_orow;
    logic [7:0]         r_ocol, n_ocol;
    logic [8:0]         r_och, n_och;
    logic signed [39:0] r_oval, n_oval;
    logic               w_we, l_we;
    logic [14:0]        w_raddr;
    logic [16:0]        l_waddr, l_raddr;
    logic [15:0]        w_rdata, l_rdata;
    logic               out_free;

    assign out_free = !r_ov || m_axis_tready;
    assign w_raddr  = r_widx;
    assign l_waddr  = {i_cmd.row[2:0], i_cmd.col, i_cmd.chan};
    assign l_raddr  = {3'(r_r0[2:0] + r_di), 8'(r_c0 + 8'(r_dj)), r_chan};

    dwc_ram #(.WIDTH(16), .DEPTH(WeightDepth)) u_wram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(i_cmd.widx), .i_wdata(i_cmd.value),
        .i_re(issue), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    dwc_ram #(.WIDTH(16), .DEPTH(LineDepth)) u_lram (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(i_cmd.value),
        .i_re(issue), .i_raddr(l_raddr), .o_rdata(l_rdata)
    );

    always_comb begin
        n_st = r_st; n_r0 = r_r0; n_c0 = r_c0; n_chan = r_chan; n_q = r_q;
        n_di = r_di; n_dj = r_dj; n_wbase = r_wbase; n_widx = r_widx;
        n_acc = r_v2 ? r_acc + 40'(r_prod) : r_acc;
        n_ov = r_ov && !m_axis_tready;
        n_olast = r_olast; n_orow = r_orow; n_ocol = r_ocol; n_och = r_och; n_oval = r_oval;
        o_pop = 1'b0; w_we = 1'b0; l_we = 1'b0; issue = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == KIND_WEIGHT) begin
                        w_we = 1'b1;
                    end else begin
                        l_we = 1'b1;
                        if (i_cmd.win) begin
                            n_r0    = i_cmd.row - 12'(i_cfg.kh) + 12'd1;
                            n_c0    = i_cmd.col - 8'(i_cfg.kw) + 8'd1;
                            n_chan  = i_cmd.chan;
                            n_q     = '0;
                            n_di    = '0;
                            n_dj    = '0;
                            n_wbase = 9'(9'(i_cmd.chan) * 9'(i_cfg.mult));
                            n_widx  = 15'(9'(i_cmd.chan) * 9'(i_cfg.mult));
                            n_acc   = '0;
                            n_st    = S_ISSUE;
                        end
                    end
                end
            end
            S_ISSUE: begin
                issue  = 1'b1;
                n_widx = r_widx + 15'(i_cfg.cm);
                if (4'(r_dj) + 4'd1 == i_cfg.kw) begin
                    n_dj = '0;
                    if (4'(r_di) + 4'd1 == i_cfg.kh) begin
                        n_st = S_DRAIN;
                    end else begin
                        n_di = r_di + 3'd1;
                    end
                end else begin
                    n_dj = r_dj + 3'd1;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2 && out_free) begin
                    n_ov    = 1'b1;
                    n_orow  = r_r0;
                    n_ocol  = r_c0;
                    n_och   = r_wbase;
                    n_oval  = r_acc;
                    n_olast = (4'(r_q) + 4'd1 == i_cfg.mult);
                    n_acc   = '0;
                    n_di    = '0;
                    n_dj    = '0;
                    if (4'(r_q) + 4'd1 == i_cfg.mult) begin
                        n_st = S_IDLE;
                    end else begin
                        n_q     = r_q + 3'd1;
                        n_wbase = r_wbase + 9'd1;
                        n_widx  = 15'(r_wbase) + 15'd1;
                        n_st    = S_ISSUE;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= $signed(w_rdata) * $signed(l_rdata);
        r_r0    <= n_r0;    r_c0  <= n_c0;  r_chan <= n_chan;
        r_q     <= n_q;     r_di  <= n_di;  r_dj   <= n_dj;
        r_wbase <= n_wbase; r_widx <= n_widx; r_acc <= n_acc;
        r_olast <= n_olast; r_orow <= n_orow; r_ocol <= n_ocol;
        r_och   <= n_och;   r_oval <= n_oval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_v1 <= 1'b0; r_v2 <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_v1 <= issue; r_v2 <= r_v1; r_ov <= n_ov;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {3'b000, r_oval, r_och, r_ocol, r_orow};
endmodule

FILE: design/depthwise_conv2d_forward.sv
`timescale 1ns / 1ps
// Depthwise 2D convolution top level, valid padding, stride 1, with channel multiplier.
// Depends on dwc_pkg, dwc_front, dwc_queue and dwc_back.
// A weight item, or a sample that completes no window, is taken in the idle state.
// A sample that completes a window is stepped through the kernel by the single
// multiply-accumulate unit once per multiplier output; no new item is popped until
// its last result is registered. Reset clears positions and output valid, config to one.
module depthwise_conv2d_forward (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // weight_index, item_value
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // out_row, out_col, out_channel, out_value
    output logic        m_axis_tlast
);
    import dwc_pkg::*;

    t_cmd push_cmd, head_cmd;
    t_cfg cfg;
    logic push, full, pop, empty;

    dwc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .i_full(full), .o_push(push), .o_cmd(push_cmd), .o_cfg(cfg)
    );

    dwc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_cmd(push_cmd), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_cmd(head_cmd)
    );

    dwc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(empty), .i_cmd(head_cmd), .o_pop(pop), .i_cfg(cfg),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the depthwise convolution block: streams weights and
// samples through several register settings and compares every result item.
// Depends on dwc_pkg and depthwise_conv2d_forward.
module tb;
    import dwc_pkg::*;

    typedef struct {
        logic [11:0]        row;
        logic [7:0]         col;
        logic [8:0]         chan;
        logic signed [39:0] value;
        logic               last;
    } t_conv_out;

    class t_conv_scoreboard;
        logic [12:0] regs[6];
        shortint     weights[WeightDepth];
        shortint     lines[LineDepth];
        int unsigned row_at, col_at, chan_at;
        t_conv_out   pending_q[$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = 13'd1;
            row_at = 0; col_at = 0; chan_at = 0; errors = 0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void set_reg(logic [2:0] idx, logic [12:0] data);
            case (idx)
                REG_HEIGHT:   regs[0] = data;
                REG_WIDTH:    regs[1] = data & 13'h1FF;
                REG_CHANNELS: regs[2] = data & 13'h7F;
                REG_MULT:     regs[3] = data & 13'hF;
                REG_KHEIGHT:  regs[4] = data & 13'hF;
                REG_KWIDTH:   regs[5] = data & 13'hF;
                default:      return;
            endcase
            row_at = 0; col_at = 0; chan_at = 0;
        endfunction

        function void note_item(logic kind, logic [14:0] idx, logic signed [15:0] v);
            int unsigned h, w, c, m, kh, kw, r0, c0, slot;
            longint acc;
            t_conv_out res;
            if (kind == KIND_WEIGHT) begin
                weights[idx] = v;
                return;
            end
            h  = clamp(regs[0], MaxHeight);
            w  = clamp(regs[1], MaxWidth);
            c  = clamp(regs[2], MaxChannels);
            m  = clamp(regs[3], MaxMult);
            kh = clamp(regs[4], MaxKernel);
            kw = clamp(regs[5], MaxKernel);
            if (row_at >= h) row_at = 0;
            if (col_at >= w) col_at = 0;
            if (chan_at >= c) chan_at = 0;
            lines[((row_at % MaxKernel) * MaxWidth + col_at) * MaxChannels + chan_at] = v;
            if (row_at + 1 >= kh && col_at + 1 >= kw) begin
                r0 = row_at + 1 - kh;
                c0 = col_at + 1 - kw;
                for (int q = 0; q < m; q++) begin
                    acc = 0;
                    for (int di = 0; di < kh; di++) begin
                        slot = (r0 + di) % MaxKernel;
                        for (int dj = 0; dj < kw; dj++) begin
                            acc += longint'(weights[((di * kw + dj) * c + chan_at) * m + q]) *
                                   longint'(lines[(slot * MaxWidth + c0 + dj) * MaxChannels
                                                  + chan_at]);
                        end
                    end
                    res.row   = r0[11:0];
                    res.col   = c0[7:0];
                    res.chan  = 9'(chan_at * m + q);
                    res.value = acc[39:0];
                    res.last  = (q + 1 == m);
                    pending_q.push_back(res);
                end
            end
            chan_at++;
            if (chan_at >= c) begin
                chan_at = 0;
                col_at++;
                if (col_at >= w) begin
                    col_at = 0;
                    row_at++;
                    if (row_at >= h) row_at = 0;
                end
            end
        endfunction

        function void check_result(logic [71:0] d, logic l);
            t_conv_out e;
            if (pending_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h last %b", $time, d, l);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (d[11:0] !== e.row) begin
                $display("%0t row: expected %0d actual %0d", $time, e.row, d[11:0]);
                errors++;
            end
            if (d[19:12] !== e.col) begin
                $display("%0t col: expected %0d actual %0d", $time, e.col, d[19:12]);
                errors++;
            end
            if (d[28:20] !== e.chan) begin
                $display("%0t channel: expected %0d actual %0d", $time, e.chan, d[28:20]);
                errors++;
            end
            if (d[68:29] !== e.value) begin
                $display("%0t value: expected %h actual %h", $time, e.value, d[68:29]);
                errors++;
            end
            if (d[71:69] !== 3'd0) begin
                $display("%0t pad: expected 0 actual %h", $time, d[71:69]);
                errors++;
            end
            if (l !== e.last) begin
                $display("%0t last: expected %b actual %b", $time, e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [12:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    t_conv_scoreboard sb = new();
    int gap_pct   = 0;
    int stall_pct = 0;
    int quiet     = 0;

    depthwise_conv2d_forward u_top (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= 20000) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_item(logic kind, logic [14:0] idx, logic [15:0] v);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, v, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(kind, idx, v);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (sb.pending_q.size() == 0);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_regs(int h, int w, int c, int m, int kh, int kw);
        int vals[6];
        vals = '{h, w, c, m, kh, kw};
        drain();
        for (int i = 0; i < 6; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= 13'(vals[i]);
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(3'(i), 13'(vals[i]));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_stream(int n);
        logic [15:0] v;
        for (int i = 0; i < n; i++) begin
            v = 16'($urandom);
            if ($urandom_range(4) == 0) begin
                case ($urandom_range(3))
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    2: v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            if ($urandom_range(9) == 0) begin
                send_item(KIND_WEIGHT, 15'($urandom), v);
            end else begin
                send_item(KIND_SAMPLE, 15'($urandom), v);
            end
        end
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 53; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 53; end
            default: begin gap_pct = 27; stall_pct = 27; end
        endcase
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_WEIGHT;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the weight entries that the register settings below read, so that
        // no window reads an unwritten entry.
        for (int i = 0; i < 48; i++) begin
            send_item(KIND_WEIGHT, 15'(i), 16'($urandom));
        end

        send_item(KIND_SAMPLE, 15'h7FFF, 16'h7FFF);
        send_item(KIND_SAMPLE, 15'h0000, 16'h8000);
        send_item(KIND_WEIGHT, 15'h0000, 16'h7FFF);
        send_item(KIND_SAMPLE, 15'h0000, 16'h7FFF);
        send_item(KIND_SAMPLE, 15'h0000, 16'h8000);
        send_item(KIND_WEIGHT, 15'h0000, 16'h8000);
        send_item(KIND_SAMPLE, 15'h0000, 16'h8000);
        send_item(KIND_SAMPLE, 15'h0000, 16'hFFFF);
        send_item(KIND_SAMPLE, 15'h0000, 16'h0000);
        send_item(KIND_WEIGHT, 15'h7FFF, 16'h0000);

        write_regs(8191, 511, 127, 15, 15, 15);
        for (int i = 0; i < 5; i++) send_item(KIND_SAMPLE, 15'($urandom), 16'($urandom));
        write_regs(0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++) send_item(KIND_SAMPLE, 15'($urandom), 16'($urandom));
        write_regs(2, 2, 1, 1, 3, 1);
        for (int i = 0; i < 4; i++) send_item(KIND_SAMPLE, 15'($urandom), 16'($urandom));

        write_regs(3, 4, 2, 2, 2, 3);
        set_idle(0);
        random_stream(15);
        write_regs(10, 2, 1, 1, 8, 2);
        set_idle(1);
        random_stream(40);
        write_regs(2, 5, 3, 1, 3, 2);
        set_idle(2);
        random_stream(5);
        write_regs(4, 6, 4, 3, 2, 2);
        set_idle(3);
        random_stream(35);
        write_regs(5, 3, 2, 8, 1, 1);
        for (int p = 0; p < 4; p++) begin
            set_idle(p);
            random_stream(6);
        end

        set_idle(0);
        drain();
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
